>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define DCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset
`define DCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and constants of the directed cycle finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int VERTEX_W         = 6;
    localparam int OP_W             = 2;
    localparam int COUNT_W          = 7;
    localparam logic [COUNT_W-1:0] VC_RESET = 7'd64;

    // operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_INIT,
        ST_REACH_RD,
        ST_REACH_UPD,
        ST_ADJ_UPD,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_NONE
    } dcf_state_t;

    // control from the sequencer to the graph memory
    typedef struct packed {
        logic wr_edge;
        logic clear;
        logic rd_en;
        logic rd_rev;
    } gm_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/directed_cycle_finder_core.sv
// ----------------------------------------------------------------------------
// directed_cycle_finder_core
// Adjacency store with a depth-first cycle search sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* words carry a command in s_tuser (add edge, search, clear) and the
//   edge's tail and head vertices in s_tdata. Add and clear give no result.
//   A search tries start vertices in ascending order and returns
//   the first cycle found, one m_* word per vertex in path order,
//   m_tuser = 1, m_tlast on the final vertex; with no cycle it returns one
//   word with m_tuser = 0, vertex 0 and m_tlast set.
//   cfg_* writes vertex_count; write it only while the block is idle.
//   Each walk step gathers the backward reachability set through the
//   predecessor rows of the graph memory, then reads the current vertex's
//   successor row; each start vertex tried adds a start and an init state.
//   Each result word is read from the path buffer before the output register.
//   One command is worked on at a time.
//   Reset empties the graph and sets vertex_count to 64. A stalled m_tready
//   holds the output word; the sequencer waits for the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module directed_cycle_finder_core #(
    parameter int MAX_VERTICES = dcf_pkg::DEF_MAX_VERTICES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: src_vertex [5:0], dst_vertex [11:6], zero pad [15:12]
    input  wire logic [15:0] s_tdata,
    // s_tuser: operation [1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: vertex [5:0], zero pad [7:6]
    output logic      [7:0]  m_tdata,
    // m_tuser: found [0]
    output logic             m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import dcf_pkg::*;

    localparam int N  = MAX_VERTICES;
    localparam int AW = $clog2(N);
    localparam int DW = $clog2(N + 1);

    dcf_state_t state_reg, state_next;

    logic [COUNT_W-1:0] vc_reg;
    logic [DW-1:0]      n_reg, start_reg, depth_reg, k_reg;
    logic [AW-1:0]      cur_reg;
    logic [N-1:0]       nmask_reg, on_walk_reg, reach_reg, pend_reg;
    logic               out_valid_reg, out_found_reg, out_last_reg;
    logic [VERTEX_W-1:0] out_vertex_reg;

    gm_ctl_t       gm_ctl;
    logic [AW-1:0] gm_rd_addr;
    logic [N-1:0]  gm_rd_data;
    logic          pb_wr_en, pb_rd_en;
    logic [AW-1:0] pb_wr_addr, pb_wr_data, pb_rd_data;

    logic [VERTEX_W-1:0] f_src, f_dst;
    logic          s_fire, edge_ok, out_free, emit_last;
    logic [DW-1:0] n_sat;
    logic [N-1:0]  nmask_new, start_oh, row, new_r, cand;
    logic [AW-1:0] start_v, pick_x, v_sel;
    logic          pend_any, cand_any, hit_start;
    logic          load_out;

    // lowest set bit of a vertex vector
    function automatic logic [AW-1:0] lowest_bit(input logic [N-1:0] vec);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (vec[i]) idx = AW'(i);
        end
        return idx;
    endfunction

    assign f_src   = s_tdata[5:0];
    assign f_dst   = s_tdata[11:6];
    assign s_fire  = s_tvalid && s_tready;
    assign edge_ok = (32'(f_src) < N) && (32'(f_dst) < N);
    assign out_free = !out_valid_reg || m_tready;

    // vertex count saturates at the matrix size
    assign n_sat = (32'(vc_reg) > N) ? DW'(N) : DW'(vc_reg);
    always_comb begin
        for (int i = 0; i < N; i++) nmask_new[i] = (i < int'(n_sat));
    end

    // walk datapath terms
    assign start_v   = start_reg[AW-1:0];
    assign start_oh  = N'(1) << start_v;
    assign pend_any  = |pend_reg;
    assign pick_x    = lowest_bit(pend_reg);
    assign row       = gm_rd_data & nmask_reg;
    assign new_r     = row & ~on_walk_reg & ~reach_reg;
    assign cand      = (row & ~on_walk_reg & reach_reg) | (row & start_oh);
    assign cand_any  = |cand;
    assign v_sel     = lowest_bit(cand);
    assign hit_start = (v_sel == start_v);
    assign emit_last = ((k_reg + DW'(1)) == depth_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == OP_SEARCH) state_next = ST_START;
            end
            ST_START:     state_next = (start_reg < n_reg) ? ST_INIT : ST_NONE;
            ST_INIT:      state_next = ST_REACH_RD;
            ST_REACH_RD:  state_next = pend_any ? ST_REACH_UPD : ST_ADJ_UPD;
            ST_REACH_UPD: state_next = ST_REACH_RD;
            ST_ADJ_UPD: begin
                if (!cand_any)     state_next = ST_START;
                else if (hit_start) state_next = ST_EMIT_RD;
                else               state_next = ST_REACH_RD;
            end
            ST_EMIT_RD:   state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (out_free) state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            ST_NONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready   = 1'b0;
        gm_ctl     = '0;
        gm_rd_addr = cur_reg;
        pb_wr_en   = 1'b0;
        pb_wr_addr = '0;
        pb_wr_data = start_v;
        pb_rd_en   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                gm_ctl.wr_edge = s_fire && s_tuser == OP_ADD && edge_ok;
                gm_ctl.clear   = s_fire && s_tuser == OP_CLEAR;
            end
            ST_INIT: begin
                pb_wr_en = 1'b1;
            end
            ST_REACH_RD: begin
                gm_ctl.rd_en  = 1'b1;
                gm_ctl.rd_rev = pend_any;
                gm_rd_addr    = pend_any ? pick_x : cur_reg;
            end
            ST_ADJ_UPD: begin
                pb_wr_en   = cand_any && !hit_start;
                pb_wr_addr = depth_reg[AW-1:0];
                pb_wr_data = v_sel;
            end
            ST_EMIT_RD:  pb_rd_en = 1'b1;
            ST_EMIT_OUT: load_out = out_free;
            ST_NONE:     load_out = out_free;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vc_reg        <= VC_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) vc_reg <= cfg_data;
            if (load_out)      out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // walk and output datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                n_reg     <= n_sat;
                nmask_reg <= nmask_new;
                start_reg <= '0;
            end
            ST_INIT: begin
                on_walk_reg <= start_oh;
                reach_reg   <= '0;
                pend_reg    <= start_oh;
                cur_reg     <= start_v;
                depth_reg   <= DW'(1);
            end
            ST_REACH_RD: begin
                if (pend_any) pend_reg[pick_x] <= 1'b0;
            end
            ST_REACH_UPD: begin
                reach_reg <= reach_reg | new_r;
                pend_reg  <= pend_reg | new_r;
            end
            ST_ADJ_UPD: begin
                k_reg <= '0;
                if (!cand_any) begin
                    start_reg <= start_reg + DW'(1);
                end else if (!hit_start) begin
                    on_walk_reg[v_sel] <= 1'b1;
                    depth_reg          <= depth_reg + DW'(1);
                    cur_reg            <= v_sel;
                    reach_reg          <= '0;
                    pend_reg           <= start_oh;
                end
            end
            ST_EMIT_OUT: begin
                if (out_free) begin
                    out_found_reg  <= 1'b1;
                    out_vertex_reg <= VERTEX_W'(pb_rd_data);
                    out_last_reg   <= emit_last;
                    k_reg          <= k_reg + DW'(1);
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    out_found_reg  <= 1'b0;
                    out_vertex_reg <= '0;
                    out_last_reg   <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    dcf_graph_mem #(.N(N), .AW(AW)) u_graph (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (gm_ctl),
        .wr_a    (AW'(f_src)),
        .wr_b    (AW'(f_dst)),
        .rd_addr (gm_rd_addr),
        .rd_data (gm_rd_data)
    );

    dcf_path_buf #(.N(N), .AW(AW)) u_path (
        .aclk    (aclk),
        .wr_en   (pb_wr_en),
        .wr_addr (pb_wr_addr),
        .wr_data (pb_wr_data),
        .rd_en   (pb_rd_en),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (pb_rd_data)
    );

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_vertex_reg};
    assign m_tuser   = out_found_reg;
    assign m_tlast   = out_last_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> hw/rtl/dcf_graph_mem.sv
// ----------------------------------------------------------------------------
// dcf_graph_mem
// Edge matrix held twice: successor rows and predecessor rows, one row read.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_graph_mem #(
    parameter int N  = 64,
    parameter int AW = 6
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire dcf_pkg::gm_ctl_t ctl,
    input  wire logic [AW-1:0]   wr_a,
    input  wire logic [AW-1:0]   wr_b,
    input  wire logic [AW-1:0]   rd_addr,
    output logic      [N-1:0]    rd_data
);
    import dcf_pkg::*;

    logic [N-1:0] fwd_mem [N];
    logic [N-1:0] rev_mem [N];
    logic [N-1:0] fwd_ok_reg;
    logic [N-1:0] rev_ok_reg;
    logic [N-1:0] row_reg;
    logic         row_ok_reg;

    // row valid bits: a row that is not valid reads as no edges
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            fwd_ok_reg <= '0;
            rev_ok_reg <= '0;
        end else if (ctl.wr_edge) begin
            fwd_ok_reg[wr_a] <= 1'b1;
            rev_ok_reg[wr_b] <= 1'b1;
        end
    end

    // edge writes; an invalid row is replaced by the single new bit
    always_ff @(posedge aclk) begin
        if (ctl.wr_edge) begin
            if (fwd_ok_reg[wr_a]) fwd_mem[wr_a][wr_b] <= 1'b1;
            else                  fwd_mem[wr_a] <= N'(1) << wr_b;
            if (rev_ok_reg[wr_b]) rev_mem[wr_b][wr_a] <= 1'b1;
            else                  rev_mem[wr_b] <= N'(1) << wr_a;
        end
    end

    // registered row read; writes and reads never share a cycle
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            row_reg    <= ctl.rd_rev ? rev_mem[rd_addr] : fwd_mem[rd_addr];
            row_ok_reg <= ctl.rd_rev ? rev_ok_reg[rd_addr] : fwd_ok_reg[rd_addr];
        end
    end

    assign rd_data = row_ok_reg ? row_reg : '0;

endmodule

`default_nettype wire

>>> hw/rtl/dcf_path_buf.sv
// ----------------------------------------------------------------------------
// dcf_path_buf
// Walk vertex buffer, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_path_buf #(
    parameter int N  = 64,
    parameter int AW = 6
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_data
);
    logic [AW-1:0] buf_mem [N];

    always_ff @(posedge aclk) begin
        if (wr_en) buf_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) rd_data <= buf_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/dcf_checker.sv
// ----------------------------------------------------------------------------
// dcf_checker
// Port-level checks of the cycle finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dcf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [15:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [6:0]  cfg_data,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a stalled output word holds
    `DCF_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

    // a no-cycle word always ends the search
    `DCF_ASSERT(a_none_last, aclk, aresetn, m_tvalid && !m_tuser |-> m_tlast, "no-cycle word without last")

    // no command yields a result in the cycle after it is taken
    `DCF_ASSERT(a_no_instant, aclk, aresetn, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result right after a command")

    // reset empties the output register
    `DCF_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind directed_cycle_finder_core dcf_checker u_dcf_checker (.*);

`default_nettype wire
